// File: hw/rtl/utf8dn_pkg.sv
`default_nettype none

package utf8dn_pkg;

  // Default depth of the command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [15:0] REPLACEMENT  = 16'hFFFD;
  localparam logic [15:0] KANA_OFFSET  = 16'h0060;
  localparam logic [15:0] HIRA_LO      = 16'h3041;
  localparam logic [15:0] HIRA_HI      = 16'h3096;
  localparam logic [15:0] HIRA_ITER_LO = 16'h309D;
  localparam logic [15:0] HIRA_ITER_HI = 16'h309F;

  localparam logic [15:0] IDEO_SPACE   = 16'h3000;
  localparam logic [15:0] IDEO_COMMA   = 16'h3001;
  localparam logic [15:0] IDEO_STOP    = 16'h3002;
  localparam logic [15:0] FW_COMMA     = 16'hFF0C;
  localparam logic [15:0] FW_SEMICOLON = 16'hFF1B;
  localparam logic [15:0] FW_COLON     = 16'hFF1A;
  localparam logic [15:0] FW_EXCLAM    = 16'hFF01;
  localparam logic [15:0] FW_QUESTION  = 16'hFF1F;
  localparam logic [15:0] FW_LPAREN    = 16'hFF08;
  localparam logic [15:0] FW_RPAREN    = 16'hFF09;

  // One classified input byte: pre FFFDs, an optional middle unit, post FFFDs.
  // A command with no unit at all and fin set stands for a bare end marker.
  typedef struct packed {
    logic [1:0]  pre_cnt;
    logic        mid_valid;
    logic [15:0] mid_unit;
    logic [1:0]  post_cnt;
    logic        fin;
  } cmd_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Punctuation folding, then hiragana to katakana
  function automatic logic [15:0] normalize(input logic [15:0] cp);
    logic [15:0] v;
    case (cp)
      IDEO_SPACE:   v = 16'h0020;
      IDEO_COMMA:   v = 16'h002C;
      IDEO_STOP:    v = 16'h002E;
      FW_COMMA:     v = 16'h002C;
      FW_SEMICOLON: v = 16'h003B;
      FW_COLON:     v = 16'h003A;
      FW_EXCLAM:    v = 16'h0021;
      FW_QUESTION:  v = 16'h003F;
      FW_LPAREN:    v = 16'h0028;
      FW_RPAREN:    v = 16'h0029;
      default:      v = cp;
    endcase
    if ((v >= HIRA_LO && v <= HIRA_HI) || (v >= HIRA_ITER_LO && v <= HIRA_ITER_HI)) begin
      v = v + KANA_OFFSET;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/utf8_decode_normalize.sv
`default_nettype none

// Channel   Dir  tdata                tuser         tlast
// s_axis    in   [7:0] text_byte      -             final_byte
// m_axis    out  [15:0] code_unit     unit_present  text_end
//
// The front decodes one byte per cycle while the queue is not full and writes one
// command per byte that yields items; the back turns each command into 1 to 4
// items, one per cycle while the output is ready, so sustained rate is one byte
// per cycle while each byte yields at most one item; more per byte hold the back.
// s_axis_tready drops only while the command queue is full.
// Reset clears the sequence state, the queue and the output valid.
module utf8_decode_normalize #(
  parameter int unsigned QueueDepth = utf8dn_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  wire logic        s_axis_tlast,   // final_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [15:0] code_unit
  output logic             m_axis_tuser,   // unit_present
  output logic             m_axis_tlast    // text_end
);
  import utf8dn_pkg::*;

  cmd_t      push_cmd;
  cmd_t      head_cmd;
  logic      push;
  logic      pop;
  q_status_t q_status;

  utf8dn_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_status_i    (q_status),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  utf8dn_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .pop_i    (pop),
    .head_o   (head_cmd),
    .status_o (q_status)
  );

  utf8dn_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_cmd),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// File: hw/rtl/utf8dn_front.sv
`default_nettype none

module utf8dn_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,   // [7:0] text_byte
  input  wire logic                 s_axis_tlast,   // final_byte
  input  wire utf8dn_pkg::q_status_t q_status_i,
  output logic                      push_o,
  output utf8dn_pkg::cmd_t          cmd_o
);
  import utf8dn_pkg::*;

  logic [20:0] partial_q, partial_d;
  logic [1:0]  held_q, held_d;
  logic [1:0]  needed_q, needed_d;

  logic        accept;
  logic        is_cont;
  logic [20:0] shifted;
  logic [20:0] value;
  logic        value_valid;
  cmd_t        cmd;

  assign s_axis_tready = !q_status_i.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Classify the byte and work out the next sequence state
  always_comb begin
    is_cont     = (s_axis_tdata[7:6] == 2'b10);
    shifted     = {partial_q[14:0], s_axis_tdata[5:0]};
    value       = '0;
    value_valid = 1'b0;
    cmd         = '0;
    partial_d   = '0;
    held_d      = '0;
    needed_d    = '0;

    if (held_q != 2'd0 && is_cont) begin
      if (needed_q <= 2'd1) begin
        value       = shifted;
        value_valid = 1'b1;
      end else begin
        partial_d = shifted;
        held_d    = held_q + 2'd1;
        needed_d  = needed_q - 2'd1;
      end
    end else begin
      // broken sequence: one FFFD per held byte, then decode this byte afresh
      cmd.pre_cnt = held_q;
      if (!s_axis_tdata[7]) begin
        value       = {13'd0, s_axis_tdata};
        value_valid = 1'b1;
      end else if (s_axis_tdata[7:5] == 3'b110) begin
        partial_d = {16'd0, s_axis_tdata[4:0]};
        held_d    = 2'd1;
        needed_d  = 2'd1;
      end else if (s_axis_tdata[7:4] == 4'b1110) begin
        partial_d = {17'd0, s_axis_tdata[3:0]};
        held_d    = 2'd1;
        needed_d  = 2'd2;
      end else if (s_axis_tdata[7:3] == 5'b11110) begin
        partial_d = {18'd0, s_axis_tdata[2:0]};
        held_d    = 2'd1;
        needed_d  = 2'd3;
      end else begin
        // stray continuation or F8-FF
        cmd.mid_valid = 1'b1;
        cmd.mid_unit  = REPLACEMENT;
      end
    end

    // values above FFFF are dropped
    if (value_valid && value[20:16] == 5'd0) begin
      cmd.mid_valid = 1'b1;
      cmd.mid_unit  = normalize(value[15:0]);
    end

    // end of text flushes whatever is still held
    if (s_axis_tlast) begin
      cmd.post_cnt = held_d;
      cmd.fin      = 1'b1;
      partial_d    = '0;
      held_d       = '0;
      needed_d     = '0;
    end
  end

  assign cmd_o  = cmd;
  assign push_o = accept && (cmd.fin || cmd.mid_valid || cmd.pre_cnt != 2'd0);

  // Sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      held_q    <= '0;
      needed_q  <= '0;
    end else if (accept) begin
      partial_q <= partial_d;
      held_q    <= held_d;
      needed_q  <= needed_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/utf8dn_queue.sv
`default_nettype none

module utf8dn_queue #(
  parameter int unsigned Depth = utf8dn_pkg::QUEUE_DEPTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire utf8dn_pkg::cmd_t      cmd_i,
  input  wire logic                  pop_i,
  output utf8dn_pkg::cmd_t           head_o,
  output utf8dn_pkg::q_status_t      status_o
);
  import utf8dn_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign status_o.full  = (count_q == FullCnt);
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Command storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/utf8dn_back.sv
`default_nettype none

module utf8dn_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire utf8dn_pkg::cmd_t      head_i,
  input  wire utf8dn_pkg::q_status_t q_status_i,
  output logic                       pop_o,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [15:0]                m_axis_tdata,  // [15:0] code_unit
  output logic                       m_axis_tuser,  // unit_present
  output logic                       m_axis_tlast   // text_end
);
  import utf8dn_pkg::*;

  logic [1:0]  k_q;
  logic        valid_q;
  logic [15:0] unit_q;
  logic        present_q;
  logic        end_q;

  logic [2:0]  total;
  logic        marker;
  logic        last;
  logic        load;
  logic [15:0] unit;

  // Expand the head command, one item per cycle while the output is ready
  always_comb begin
    total  = {1'b0, head_i.pre_cnt} + {2'b0, head_i.mid_valid} + {1'b0, head_i.post_cnt};
    marker = (total == 3'd0);
    last   = marker || ({1'b0, k_q} == total - 3'd1);
    if (marker) begin
      unit = '0;
    end else if (head_i.mid_valid && k_q == head_i.pre_cnt) begin
      unit = head_i.mid_unit;
    end else begin
      unit = REPLACEMENT;
    end
  end

  assign load  = !q_status_i.empty && (!valid_q || m_axis_tready);
  assign pop_o = load && last;

  // Output register control and item index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      k_q     <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      k_q     <= last ? 2'd0 : k_q + 2'd1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      unit_q    <= unit;
      present_q <= !marker;
      end_q     <= head_i.fin && last;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = unit_q;
  assign m_axis_tuser  = present_q;
  assign m_axis_tlast  = end_q;

endmodule

`default_nettype wire
